// ===== hw/rtl/ssfg_pkg.sv =====
// Shared types, codes and constants of the shaped slew function generator.
// Depends on nothing; ssfg_regs, ssfg_alu and the top level refer to it by scope.
`timescale 1ns / 1ps

package ssfg_pkg;

    // Operations of the shared shift-add unit.
    typedef enum logic [1:0] {
        ALU_MUL = 2'b01,
        ALU_DIV = 2'b10
    } ssfg_alu_op_t;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_RANGE = 3'd0;
    localparam logic [2:0] REG_SHAPE = 3'd1;
    localparam logic [2:0] REG_RISE  = 3'd2;
    localparam logic [2:0] REG_FALL  = 3'd3;
    localparam logic [2:0] REG_CYCLE = 3'd4;
    localparam logic [2:0] REG_TICK  = 3'd5;

    // Range selector codes.
    localparam logic [1:0] RANGE_MEDIUM = 2'd0;
    localparam logic [1:0] RANGE_FAST   = 2'd1;

    localparam logic [23:0] TICK_RESET = 24'd89478;

    // Number of quotient bits produced by the divider.
    localparam int DIV_BITS = 40;

    typedef struct packed {
        logic [1:0]         range_sel;
        logic signed [15:0] shape;
        logic [15:0]        rise_knob;
        logic [15:0]        fall_knob;
        logic               cycle_sw;
        logic [23:0]        tick;
    } ssfg_cfg_t;

    typedef struct packed {
        logic         start;
        ssfg_alu_op_t op;
        logic [63:0]  opa;
        logic [63:0]  opb;
    } ssfg_alu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } ssfg_alu_st_t;

    // 2^(-k/16) in Q16 for k = 0..16.
    function automatic logic [16:0] exp2_tab(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/ssfg_in_if.sv =====
// Input channel of the slew generator: valid/ready handshake plus one item.
// Depends on nothing.
`timescale 1ns / 1ps

interface ssfg_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         voice;
    logic signed [23:0] signal_in;
    logic signed [23:0] trigger_in;
    logic               button_held;
    logic signed [23:0] rise_cv;
    logic signed [23:0] fall_cv;
    logic signed [23:0] expo_cv;
    logic signed [23:0] cycle_cv;

    modport source (output valid, voice, signal_in, trigger_in, button_held,
                    rise_cv, fall_cv, expo_cv, cycle_cv, input ready);
    modport sink (input valid, voice, signal_in, trigger_in, button_held,
                  rise_cv, fall_cv, expo_cv, cycle_cv, output ready);
endinterface

// ===== hw/rtl/ssfg_out_if.sv =====
// Result channel of the slew generator: valid/ready handshake plus one item.
// Depends on nothing.
`timescale 1ns / 1ps

interface ssfg_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         voice_out;
    logic signed [23:0] level_out;
    logic               is_rising;
    logic               is_falling;
    logic               end_pulse;

    modport source (output valid, voice_out, level_out, is_rising, is_falling,
                    end_pulse, input ready);
    modport sink (input valid, voice_out, level_out, is_rising, is_falling,
                  end_pulse, output ready);
endinterface

// ===== hw/rtl/ssfg_regs.sv =====
// Configuration registers of the slew generator behind an APB-style port.
// Depends on ssfg_pkg.
`timescale 1ns / 1ps

module ssfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output ssfg_pkg::ssfg_cfg_t cfg
);

    ssfg_pkg::ssfg_cfg_t cfg_reg;
    logic [2:0]          idx;
    logic                wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_sel <= 2'd0;
            cfg_reg.shape     <= 16'sd0;
            cfg_reg.rise_knob <= 16'd0;
            cfg_reg.fall_knob <= 16'd0;
            cfg_reg.cycle_sw  <= 1'b0;
            cfg_reg.tick      <= ssfg_pkg::TICK_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                ssfg_pkg::REG_RANGE: cfg_reg.range_sel <= pwdata[1:0];
                ssfg_pkg::REG_SHAPE: cfg_reg.shape     <= pwdata[15:0];
                ssfg_pkg::REG_RISE:  cfg_reg.rise_knob <= pwdata[15:0];
                ssfg_pkg::REG_FALL:  cfg_reg.fall_knob <= pwdata[15:0];
                ssfg_pkg::REG_CYCLE: cfg_reg.cycle_sw  <= pwdata[0];
                ssfg_pkg::REG_TICK:  cfg_reg.tick      <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            ssfg_pkg::REG_RANGE: prdata = {30'd0, cfg_reg.range_sel};
            ssfg_pkg::REG_SHAPE: prdata = {16'd0, cfg_reg.shape};
            ssfg_pkg::REG_RISE:  prdata = {16'd0, cfg_reg.rise_knob};
            ssfg_pkg::REG_FALL:  prdata = {16'd0, cfg_reg.fall_knob};
            ssfg_pkg::REG_CYCLE: prdata = {31'd0, cfg_reg.cycle_sw};
            ssfg_pkg::REG_TICK:  prdata = {8'd0, cfg_reg.tick};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

// ===== hw/rtl/ssfg_alu.sv =====
// Shared bit-serial arithmetic unit: shift-add multiply and restoring divide.
// Depends on ssfg_pkg.
`timescale 1ns / 1ps

module ssfg_alu (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ssfg_pkg::ssfg_alu_req_t req,
    output ssfg_pkg::ssfg_alu_st_t  st
);

    localparam int CNT_W = $clog2(ssfg_pkg::DIV_BITS + 1);

    ssfg_pkg::ssfg_alu_op_t op_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [63:0]            acc_reg;
    logic [63:0]            mcand_reg;
    logic [63:0]            mplier_reg;
    logic [26:0]            rem_reg;
    logic [CNT_W-1:0]       cnt_reg;

    logic [27:0] rem_sh;
    logic        q_bit;
    logic [27:0] rem_sub;

    // One restoring division step: the dividend bits shift out of mcand_reg.
    always_comb
    begin
        rem_sh  = {rem_reg, mcand_reg[ssfg_pkg::DIV_BITS-1]};
        q_bit   = (rem_sh >= {1'b0, mplier_reg[26:0]});
        rem_sub = rem_sh - {1'b0, mplier_reg[26:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ssfg_pkg::ALU_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= CNT_W'(ssfg_pkg::DIV_BITS);
            end
            else if (busy_reg)
            begin
                if (op_reg == ssfg_pkg::ALU_MUL)
                begin
                    if (mplier_reg == 64'd0)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg    <= 64'd0;
            mcand_reg  <= req.opa;
            mplier_reg <= req.opb;
            rem_reg    <= 27'd0;
        end
        else if (busy_reg)
        begin
            if (op_reg == ssfg_pkg::ALU_MUL)
            begin
                if (mplier_reg[0])
                begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg  <= {mcand_reg[62:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[63:1]};
            end
            else
            begin
                rem_reg <= q_bit ? rem_sub[26:0] : rem_sh[26:0];
                // Quotient bits fill acc from the bottom.
                acc_reg   <= {acc_reg[62:0], q_bit};
                mcand_reg <= {mcand_reg[62:0], 1'b0};
            end
        end
    end

    assign st.done   = done_reg;
    assign st.result = acc_reg;

endmodule

// ===== hw/rtl/shaped_slew_function_generator.sv =====
// Top level of the shaped rise/fall slew function generator.
// Depends on ssfg_pkg, ssfg_in_if, ssfg_out_if, ssfg_regs and ssfg_alu.
`timescale 1ns / 1ps

// How to use this block:
// Each item on in_ch carries one voice's sample: the input voltage, the
// trigger voltage, the button and the CVs, all Q8.16 volts. The block
// updates that voice's stored level, gate, Schmitt state and end-of-cycle
// timer, and returns exactly one item on out_ch with the new level and the
// rising, falling and end-of-cycle flags.
// Items are handled one at a time: in_ch.ready returns only when the
// result of the item in work enters the output register. An item's time
// is set by the single bit-serial shift-add unit, which works one multiplier
// bit or quotient bit per cycle over these operations in order: two
// multiplies for the rate factor, then a 40-step division for the log shape
// or two multiplies for the exponential shape, and one crossfade multiply.
// in_ch.ready is high only while the sequencer is idle.
// Results sit in an output register. If the receiver stalls, the next item
// is still accepted and worked on, and its result waits until the previous
// one has been taken.
// Registers are to be written over the APB-style port only while no item is
// in work; the user is bound to this, the block does not enforce it.
// Reset clears all voice state and both channels, resets the configuration.
module shaped_slew_function_generator #(
    parameter int VOICES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    ssfg_in_if.sink     in_ch,
    ssfg_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    // Voice index to state slot, worked out at elaboration.
    function automatic logic [63:0] build_vmap();
        logic [63:0] mp;
        mp = 64'd0;
        for (int i = 0; i < 16; i++)
        begin
            mp[i*4 +: 4] = 4'(i % VOICES);
        end
        return mp;
    endfunction

    localparam logic [63:0] VMAP = build_vmap();

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_PREP  = 11'b00000000010,
        S_MULTM = 11'b00000000100,
        S_MULK  = 11'b00000001000,
        S_SHIFT = 11'b00000010000,
        S_DIV   = 11'b00000100000,
        S_EXP1  = 11'b00001000000,
        S_EXP2  = 11'b00010000000,
        S_MULP  = 11'b00100000000,
        S_FIN   = 11'b01000000000,
        S_SPARE = 11'b10000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    ssfg_pkg::ssfg_cfg_t     cfg;
    ssfg_pkg::ssfg_alu_req_t alu_req;
    ssfg_pkg::ssfg_alu_st_t  alu_st;

    ssfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssfg_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .st    (alu_st)
    );

    // Per-voice state.
    logic signed [23:0] level_reg  [VOICES];
    logic               gate_reg   [VOICES];
    logic               schm_reg   [VOICES];
    logic [23:0]        pulse_reg  [VOICES];

    // Captured item.
    logic [3:0]         voice_reg;
    logic [VW-1:0]      vidx_reg;
    logic signed [23:0] sig_reg;
    logic signed [23:0] trg_reg;
    logic               btn_reg;
    logic signed [23:0] rcv_reg;
    logic signed [23:0] fcv_reg;
    logic signed [23:0] ecv_reg;
    logic signed [23:0] ccv_reg;

    // Working registers.
    logic signed [24:0] tgt_reg;
    logic signed [25:0] d_reg;
    logic [24:0]        ad_reg;
    logic               geff_reg;
    logic               schm_new_reg;
    logic [3:0]         n_reg;
    logic [16:0]        m_reg;
    logic [9:0]         k_reg;
    logic [63:0]        prod_reg;
    logic [34:0]        a_reg;
    logic [22:0]        lin_reg;
    logic [14:0]        p_reg;
    logic [27:0]        oth_reg;
    logic               issued_reg;

    // Output register.
    logic               out_valid_reg;
    logic [3:0]         out_voice_reg;
    logic signed [23:0] out_level_reg;
    logic               out_rise_reg;
    logic               out_fall_reg;
    logic               out_pulse_reg;

    logic in_acc;
    logic out_free;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    // ---------------- Preparation: Schmitt trigger, target, time CV -------
    logic signed [24:0] tsum;
    logic               sch_on;
    logic               sch_off;
    logic               sch_old;
    logic               trig;
    logic               geff;
    logic signed [24:0] target;
    logic signed [25:0] diff;
    logic [19:0]        rk10;
    logic [19:0]        fk10;
    logic signed [26:0] tot_r;
    logic signed [26:0] tot_f;
    logic signed [26:0] cv_raw;
    logic [19:0]        cv;
    logic [16:0]        t0;
    logic [16:0]        t1;
    logic [11:0]        tdiff;
    logic [23:0]        tprod;
    logic [9:0]         k_val;

    always_comb
    begin
        tsum    = (btn_reg ? 25'sd1310720 : 25'sd0) + 25'(trg_reg);
        sch_on  = (tsum >= 25'sd262144);
        sch_off = (tsum <= 25'sd13107);
        sch_old = schm_reg[vidx_reg];
        trig    = !sch_old && sch_on;
        geff    = gate_reg[vidx_reg] || trig;
        target  = geff ? 25'sd655360 : 25'(sig_reg);
        diff    = 26'(target) - 26'(level_reg[vidx_reg]);
        rk10    = ({4'd0, cfg.rise_knob} << 3) + ({4'd0, cfg.rise_knob} << 1);
        fk10    = ({4'd0, cfg.fall_knob} << 3) + ({4'd0, cfg.fall_knob} << 1);
        tot_r   = $signed({7'd0, rk10}) + 27'(rcv_reg) - 27'(ecv_reg);
        tot_f   = $signed({7'd0, fk10}) + 27'(fcv_reg) - 27'(ecv_reg);
        if (diff > 26'sd0)
        begin
            cv_raw = tot_r;
        end
        else if (diff < 26'sd0)
        begin
            cv_raw = tot_f;
        end
        else
        begin
            cv_raw = 27'sd0;
        end
        if (cv_raw < 27'sd0)
        begin
            cv = 20'd0;
        end
        else if (cv_raw > 27'sd655360)
        begin
            cv = 20'd655360;
        end
        else
        begin
            cv = cv_raw[19:0];
        end
        // Interpolated 2^(-f) from the table on the top four fraction bits.
        t0    = ssfg_pkg::exp2_tab({1'b0, cv[15:12]});
        t1    = ssfg_pkg::exp2_tab({1'b0, cv[15:12]} + 5'd1);
        tdiff = 12'(t0 - t1);
        tprod = {12'd0, tdiff} * {12'd0, cv[11:0]};
        case (cfg.range_sel)
            ssfg_pkg::RANGE_MEDIUM: k_val = 10'd100;
            ssfg_pkg::RANGE_FAST:   k_val = 10'd1000;
            default:                k_val = 10'd10;
        endcase
    end

    // ---------------- Rate factor, linear slope and shape amount ----------
    logic [63:0] a_full;
    logic [34:0] a_val;
    logic [38:0] a_x10;
    logic [16:0] shape_mag;
    logic [31:0] p_prod;

    always_comb
    begin
        a_full    = prod_reg >> (6'd16 + {2'd0, n_reg});
        a_val     = a_full[34:0];
        a_x10     = ({4'd0, a_val} << 3) + ({4'd0, a_val} << 1);
        shape_mag = cfg.shape[15] ? 17'(-$signed({cfg.shape[15], cfg.shape}))
                                  : {1'b0, cfg.shape};
        if (cfg.shape[15])
        begin
            p_prod = {15'd0, shape_mag} * 32'd31130;
        end
        else
        begin
            p_prod = {15'd0, shape_mag} * 32'd29491;
        end
    end

    // ---------------- Final combination and state update ------------------
    logic               oth_lt;
    logic [27:0]        dmag;
    logic [27:0]        q_mag;
    logic signed [29:0] mag_s;
    logic signed [29:0] step;
    logic signed [30:0] nl_wide;
    logic signed [23:0] nl_sat;
    logic signed [25:0] rem;
    logic               rising;
    logic               falling;
    logic               eoc;
    logic signed [24:0] cyc_tot;
    logic [23:0]        pl_up;
    logic [20:0]        dec;
    logic [23:0]        pl_new;
    logic               gate_new;
    logic signed [23:0] lvl_final;

    always_comb
    begin
        oth_lt = (oth_reg < {5'd0, lin_reg});
        dmag   = oth_lt ? ({5'd0, lin_reg} - oth_reg) : (oth_reg - {5'd0, lin_reg});
        q_mag  = prod_reg[42:15];
        mag_s  = oth_lt ? (30'(lin_reg) - $signed({2'd0, q_mag}))
                        : (30'(lin_reg) + $signed({2'd0, q_mag}));
        if (d_reg > 26'sd0)
        begin
            step = mag_s;
        end
        else if (d_reg < 26'sd0)
        begin
            step = -mag_s;
        end
        else
        begin
            step = 30'sd0;
        end
        nl_wide = 31'(level_reg[vidx_reg]) + 31'(step);
        if (nl_wide > 31'sd8388607)
        begin
            nl_sat = 24'sh7FFFFF;
        end
        else if (nl_wide < -31'sd8388608)
        begin
            nl_sat = 24'sh800000;
        end
        else
        begin
            nl_sat = nl_wide[23:0];
        end
        rem     = 26'(tgt_reg) - 26'(nl_sat);
        rising  = (d_reg > 26'sd0) && (rem > 26'sd65);
        falling = (d_reg < 26'sd0) && (rem < -26'sd65);
        eoc     = (d_reg < 26'sd0) && !falling;

        // End-of-cycle pulse timer, 1 ms is 268435 in units of 2^-28 s.
        pl_up = pulse_reg[vidx_reg];
        if (eoc && (pl_up < 24'd268435))
        begin
            pl_up = 24'd268435;
        end
        dec = 21'(({1'b0, cfg.tick} + 25'd15) >> 4);
        if (dec == 21'd0)
        begin
            dec = 21'd1;
        end
        pl_new = (pl_up > {3'd0, dec}) ? (pl_up - {3'd0, dec}) : 24'd0;

        // Gate rules in priority order: the last that applies wins.
        cyc_tot  = (cfg.cycle_sw ? 25'sd655360 : 25'sd0) + 25'(ccv_reg);
        gate_new = geff_reg;
        if ((d_reg > 26'sd0) && !rising)
        begin
            gate_new = 1'b0;
        end
        if (eoc && (cyc_tot >= 25'sd262144))
        begin
            gate_new = 1'b1;
        end
        if (d_reg == 26'sd0)
        begin
            gate_new = 1'b0;
        end

        // Once the target is reached the level snaps onto it.
        lvl_final = (rising || falling) ? nl_sat : tgt_reg[23:0];
    end

    // ---------------- Shared unit requests ---------------------------------
    always_comb
    begin
        alu_req.start = 1'b0;
        alu_req.op    = ssfg_pkg::ALU_MUL;
        alu_req.opa   = 64'd0;
        alu_req.opb   = 64'd0;
        unique case (state_reg)
            S_MULTM:
            begin
                alu_req.opa = {40'd0, cfg.tick};
                alu_req.opb = {47'd0, m_reg};
            end
            S_MULK:
            begin
                alu_req.opa = prod_reg;
                alu_req.opb = {54'd0, k_reg};
            end
            S_DIV:
            begin
                alu_req.op  = ssfg_pkg::ALU_DIV;
                alu_req.opa = ({29'd0, a_reg} << 5) + ({29'd0, a_reg} << 3);
                alu_req.opb = {39'd0, ad_reg} + 64'd65536;
            end
            S_EXP1:
            begin
                alu_req.opa = {29'd0, a_reg};
                alu_req.opb = 64'd178145;
            end
            S_EXP2:
            begin
                alu_req.opa = prod_reg >> 16;
                alu_req.opb = {39'd0, ad_reg};
            end
            S_MULP:
            begin
                alu_req.opa = {36'd0, dmag};
                alu_req.opb = {49'd0, p_reg};
            end
            default: ;
        endcase
        if ((state_reg == S_MULTM) || (state_reg == S_MULK) || (state_reg == S_DIV) ||
            (state_reg == S_EXP1) || (state_reg == S_EXP2) || (state_reg == S_MULP))
        begin
            alu_req.start = !issued_reg;
        end
    end

    // ---------------- Sequencer --------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_acc) state_next = S_PREP;
            S_PREP:  state_next = S_MULTM;
            S_MULTM: if (alu_st.done) state_next = S_MULK;
            S_MULK:  if (alu_st.done) state_next = S_SHIFT;
            S_SHIFT: state_next = cfg.shape[15] ? S_DIV : S_EXP1;
            S_DIV:   if (alu_st.done) state_next = S_MULP;
            S_EXP1:  if (alu_st.done) state_next = S_EXP2;
            S_EXP2:  if (alu_st.done) state_next = S_MULP;
            S_MULP:  if (alu_st.done) state_next = S_FIN;
            S_FIN:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < VOICES; i++)
            begin
                level_reg[i] <= 24'sd0;
                gate_reg[i]  <= 1'b0;
                schm_reg[i]  <= 1'b0;
                pulse_reg[i] <= 24'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (alu_req.start)
            begin
                issued_reg <= 1'b1;
            end
            else if (alu_st.done)
            begin
                issued_reg <= 1'b0;
            end
            if ((state_reg == S_FIN) && out_free)
            begin
                out_valid_reg       <= 1'b1;
                level_reg[vidx_reg] <= lvl_final;
                gate_reg[vidx_reg]  <= gate_new;
                schm_reg[vidx_reg]  <= schm_new_reg;
                pulse_reg[vidx_reg] <= pl_new;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            voice_reg <= in_ch.voice;
            vidx_reg  <= VMAP[{in_ch.voice, 2'b00} +: VW];
            sig_reg   <= in_ch.signal_in;
            trg_reg   <= in_ch.trigger_in;
            btn_reg   <= in_ch.button_held;
            rcv_reg   <= in_ch.rise_cv;
            fcv_reg   <= in_ch.fall_cv;
            ecv_reg   <= in_ch.expo_cv;
            ccv_reg   <= in_ch.cycle_cv;
        end
        if (state_reg == S_PREP)
        begin
            tgt_reg      <= target;
            d_reg        <= diff;
            ad_reg       <= diff[25] ? 25'(-diff) : diff[24:0];
            geff_reg     <= geff;
            schm_new_reg <= sch_on || (sch_old && !sch_off);
            n_reg        <= cv[19:16];
            m_reg        <= t0 - {5'd0, tprod[23:12]};
            k_reg        <= k_val;
        end
        if (alu_st.done)
        begin
            prod_reg <= alu_st.result;
            if (state_reg == S_DIV)
            begin
                oth_reg <= alu_st.result[27:0];
            end
            if (state_reg == S_EXP2)
            begin
                oth_reg <= alu_st.result[59:32];
            end
        end
        if (state_reg == S_SHIFT)
        begin
            a_reg   <= a_val;
            lin_reg <= a_x10[38:16];
            p_reg   <= p_prod[29:15];
        end
        if ((state_reg == S_FIN) && out_free)
        begin
            out_voice_reg <= voice_reg;
            out_level_reg <= lvl_final;
            out_rise_reg  <= rising;
            out_fall_reg  <= falling;
            out_pulse_reg <= (pl_up != 24'd0);
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.voice_out  = out_voice_reg;
    assign out_ch.level_out  = out_level_reg;
    assign out_ch.is_rising  = out_rise_reg;
    assign out_ch.is_falling = out_fall_reg;
    assign out_ch.end_pulse  = out_pulse_reg;

    // ---------------- Assertions ------------------------------------------
    // An accepted item always starts preparation on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == S_PREP))
        else $error("accepted item did not enter preparation");

    // A new result only appears when the sequencer finishes an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !$past(out_ch.valid)) |-> $past(state_reg == S_FIN))
        else $error("result appeared without a finished item");

    // The shared unit never reports completion while the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !alu_st.done)
        else $error("arithmetic unit finished while idle");

endmodule
